// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the debug print buffer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define DPB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dpb assertion failed");

// next-cycle implication, disabled while reset is held
`define DPB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dpb assertion failed");

`endif

// ===== rtl/dpb_pkg.sv =====
// ---------------------------------------------------------------------------
// dpb_pkg
// Types, codes and constants of the debug print buffer device.
// ---------------------------------------------------------------------------
package dpb_pkg;

    localparam int RAM_BYTES_DEF = 65536;
    localparam int MAX_CHARS_DEF = 64;

    localparam logic [31:0] WIN_LO    = 32'h13FF_0000;
    localparam logic [31:0] WIN_HI    = 32'h13FF_FFFF;
    localparam logic [15:0] FLUSH_OFS = 16'h0016;
    localparam logic [15:0] START_OFS = 16'h0004;
    localparam logic [15:0] MSG_BASE  = 16'h0020;

    localparam logic [1:0] MODE_ADDR  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_EN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRC_EN = 1'b1;

    typedef struct packed {
        logic        accepted;
        logic [15:0] read_data;
        logic [7:0]  char_out;
        logic        char_valid;
        logic        clamped;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        re;
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

endpackage

// ===== rtl/dpb_ram.sv =====
// ---------------------------------------------------------------------------
// dpb_ram
// Single-port byte RAM, one read and one write per cycle at a shared address, registered read data.
// ---------------------------------------------------------------------------
module dpb_ram #(
    parameter int RAM_BYTES = dpb_pkg::RAM_BYTES_DEF
) (
    input  logic              i_clk,
    input  dpb_pkg::t_mem_req i_req,
    output logic [7:0]        o_rd_q
);
    import dpb_pkg::*;

    localparam int AW = $clog2(RAM_BYTES);

    logic [7:0] r_mem [RAM_BYTES];
    logic [7:0] r_rd_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_q <= r_mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rd_q = r_rd_q;

endmodule

// ===== rtl/dpb_out_reg.sv =====
// ---------------------------------------------------------------------------
// dpb_out_reg
// Result register between the sequencer and the output channel.
// ---------------------------------------------------------------------------
module dpb_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dpb_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output dpb_pkg::t_result o_res
);
    import dpb_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/dpb_ctrl.sv =====
// ---------------------------------------------------------------------------
// dpb_ctrl
// Transaction sequencer: pointer, registers, RAM accesses and flush loop.
// ---------------------------------------------------------------------------
module dpb_ctrl #(
    parameter int MAX_CHARS = dpb_pkg::MAX_CHARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [dpb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [31:0]                   i_bus_address,
    input  logic [15:0]                   i_write_data,
    output dpb_pkg::t_mem_req             o_mem,
    input  logic [7:0]                    i_rd_q,
    input  logic                          i_out_free,
    output logic                          o_load,
    output dpb_pkg::t_result              o_res
);
    import dpb_pkg::*;

    localparam int CW = $clog2(MAX_CHARS + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_RD_HI = 11'b000_0000_0010,
        S_RD_LO = 11'b000_0000_0100,
        S_WR_LO = 11'b000_0000_1000,
        S_FL_HI = 11'b000_0001_0000,
        S_FL_LO = 11'b000_0010_0000,
        S_CH_RD = 11'b000_0100_0000,
        S_CH_WT = 11'b000_1000_0000,
        S_CLR   = 11'b001_0000_0000,
        S_RESP  = 11'b010_0000_0000,
        S_SPARE = 11'b100_0000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [15:0]   r_ptr, n_ptr;
    logic [15:0]   r_data, n_data;
    logic [7:0]    r_hi, n_hi;
    logic [15:0]   r_caddr, n_caddr;
    logic [CW-1:0] r_count, n_count;
    logic          r_clamp, n_clamp;
    logic          r_noout, n_noout;
    logic [1:0]    r_clr, n_clr;
    t_result       r_res, n_res;
    logic          r_dev_en;
    logic          r_trc_en;

    logic          accept;
    logic          hit;
    logic [15:0]   start;
    logic [15:0]   diff;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign hit        = r_dev_en && (i_bus_address >= WIN_LO) && (i_bus_address <= WIN_HI);
    assign start      = {r_hi, i_rd_q};
    assign diff       = (r_data > start) ? (r_data - start) : 16'd0;

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_data  = r_data;
        n_hi    = r_hi;
        n_caddr = r_caddr;
        n_count = r_count;
        n_clamp = r_clamp;
        n_noout = r_noout;
        n_clr   = r_clr;
        n_res   = r_res;
        o_mem   = '0;
        o_load  = 1'b0;
        o_res   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_data       = i_write_data;
                    n_res        = '0;
                    n_res.last   = 1'b1;
                    n_caddr      = r_ptr + 16'd1;
                    case (i_mode)
                        MODE_ADDR: begin
                            if (hit) begin
                                n_ptr = i_bus_address[15:0];
                            end
                            n_res.accepted = hit;
                            n_state        = S_RESP;
                        end
                        MODE_READ: begin
                            o_mem.re   = 1'b1;
                            o_mem.addr = r_ptr;
                            n_ptr      = r_ptr + 16'd2;
                            n_state    = S_RD_HI;
                        end
                        MODE_WRITE: begin
                            n_ptr = r_ptr + 16'd2;
                            if (r_ptr == FLUSH_OFS) begin
                                o_mem.re   = 1'b1;
                                o_mem.addr = START_OFS;
                                n_state    = S_FL_HI;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.addr  = r_ptr;
                                o_mem.wdata = i_write_data[15:8];
                                n_state     = S_WR_LO;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_RD_HI: begin
                n_hi       = i_rd_q;
                o_mem.re   = 1'b1;
                o_mem.addr = r_caddr;
                n_state    = S_RD_LO;
            end
            S_RD_LO: begin
                n_res.read_data = {r_hi, i_rd_q};
                n_state         = S_RESP;
            end
            S_WR_LO: begin
                o_mem.we    = 1'b1;
                o_mem.addr  = r_caddr;
                o_mem.wdata = r_data[7:0];
                n_state     = S_RESP;
            end
            S_FL_HI: begin
                n_hi       = i_rd_q;
                o_mem.re   = 1'b1;
                o_mem.addr = START_OFS + 16'd1;
                n_state    = S_FL_LO;
            end
            S_FL_LO: begin
                if (diff > 16'(MAX_CHARS)) begin
                    n_count = CW'(MAX_CHARS);
                    n_clamp = 1'b1;
                end else begin
                    n_count = diff[CW-1:0];
                    n_clamp = 1'b0;
                end
                n_caddr       = MSG_BASE + start;
                n_res         = '0;
                n_res.clamped = n_clamp;
                n_res.last    = 1'b1;
                n_clr         = 2'd0;
                if (r_trc_en && (diff != 16'd0)) begin
                    n_noout = 1'b0;
                    n_state = S_CH_RD;
                end else begin
                    n_noout = 1'b1;
                    n_state = S_CLR;
                end
            end
            S_CH_RD: begin
                o_mem.re   = 1'b1;
                o_mem.addr = r_caddr;
                n_state    = S_CH_WT;
            end
            S_CH_WT: begin
                if (i_out_free) begin
                    o_load           = 1'b1;
                    o_res.char_out   = i_rd_q;
                    o_res.char_valid = 1'b1;
                    o_res.clamped    = r_clamp;
                    o_res.last       = (r_count == CW'(1));
                    n_caddr          = r_caddr + 16'd1;
                    n_count          = r_count - CW'(1);
                    n_state          = (r_count == CW'(1)) ? S_CLR : S_CH_RD;
                end
            end
            S_CLR: begin
                o_mem.we    = 1'b1;
                o_mem.addr  = START_OFS + {14'd0, r_clr};
                o_mem.wdata = 8'd0;
                n_clr       = r_clr + 2'd1;
                if (r_clr == 2'd3) begin
                    n_state = r_noout ? S_RESP : S_IDLE;
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    o_res   = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= 16'd0;
            r_dev_en <= 1'b0;
            r_trc_en <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_DEV_EN: r_dev_en <= i_cfg_data;
                    CFG_TRC_EN: r_trc_en <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_hi    <= n_hi;
        r_caddr <= n_caddr;
        r_count <= n_count;
        r_clamp <= n_clamp;
        r_noout <= n_noout;
        r_clr   <= n_clr;
        r_res   <= n_res;
    end

endmodule

// ===== rtl/debug_print_buffer_device.sv =====
// ---------------------------------------------------------------------------
// debug_print_buffer_device
// Debug print device: byte RAM behind a bus window with a flush to a
// character stream.
// ---------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | i_in_valid / o_in_ready | i_mode, i_bus_address, i_write_data
//  out     | o_out_valid/ i_out_ready| o_accepted .. o_last
//  cfg     | i_cfg_wr_en             | i_cfg_index, i_cfg_data
//
//  The sequencer makes at most one byte access to the RAM per cycle, so a read
//  fetches the high then the low byte and a plain write stores both in turn.
//  A flush reads the start word, reads and emits each character, clears four
//  bytes from the start word on, and responds only if it emits no character.
//  Reset clears pointer, registers and sequencer; RAM contents are kept.
//  A stalled output holds the sequencer at its next result.
// ---------------------------------------------------------------------------
module debug_print_buffer_device #(
    parameter int RAM_BYTES = dpb_pkg::RAM_BYTES_DEF,
    parameter int MAX_CHARS = dpb_pkg::MAX_CHARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [dpb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [31:0]                   i_bus_address,
    input  logic [15:0]                   i_write_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic [15:0]                   o_read_data,
    output logic [7:0]                    o_char_out,
    output logic                          o_char_valid,
    output logic                          o_clamped,
    output logic                          o_last
);
    import dpb_pkg::*;

    t_mem_req   mem_req;
    logic [7:0] rd_q;
    logic       out_free;
    logic       load;
    t_result    res;
    t_result    out_res;

    dpb_ram #(
        .RAM_BYTES(RAM_BYTES)
    ) u_ram (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rd_q(rd_q)
    );

    dpb_ctrl #(
        .MAX_CHARS(MAX_CHARS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_bus_address(i_bus_address),
        .i_write_data (i_write_data),
        .o_mem        (mem_req),
        .i_rd_q       (rd_q),
        .i_out_free   (out_free),
        .o_load       (load),
        .o_res        (res)
    );

    dpb_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (load),
        .i_res  (res),
        .o_free (out_free),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_res  (out_res)
    );

    assign o_accepted   = out_res.accepted;
    assign o_read_data  = out_res.read_data;
    assign o_char_out   = out_res.char_out;
    assign o_char_valid = out_res.char_valid;
    assign o_clamped    = out_res.clamped;
    assign o_last       = out_res.last;

endmodule

// ===== rtl/dpb_checker.sv =====
// ---------------------------------------------------------------------------
// dpb_checker
// Port-level checks of the result stream of the debug print buffer device.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dpb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_accepted,
    input logic [15:0] o_read_data,
    input logic [7:0]  o_char_out,
    input logic        o_char_valid,
    input logic        o_clamped,
    input logic        o_last
);
    `DPB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_char_out) && $stable(o_last))
    `DPB_ASSERT_IMP(a_char_only, i_clk, i_rst_n, o_out_valid && o_char_valid, !o_accepted && (o_read_data == 16'd0))
    `DPB_ASSERT_IMP(a_nochar_last, i_clk, i_rst_n, o_out_valid && !o_char_valid, o_last && (o_char_out == 8'd0))
    `DPB_ASSERT_IMP(a_acc_clean, i_clk, i_rst_n, o_out_valid && o_accepted, !o_clamped && (o_read_data == 16'd0))

endmodule

bind debug_print_buffer_device dpb_checker u_dpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_accepted  (o_accepted),
    .o_read_data (o_read_data),
    .o_char_out  (o_char_out),
    .o_char_valid(o_char_valid),
    .o_clamped   (o_clamped),
    .o_last      (o_last)
);
